[hdl/jtm_pkg.sv]
// Shared package of the joystick to mouse motion block.
// Register widths, indexes and reset values, codes and the arithmetic unit's request types.
// Depends on nothing.
`default_nettype none

package jtm_pkg;

  localparam int ZERO_W = 12;
  localparam int DB_W   = 13;
  localparam int THR_W  = 13;
  localparam int SENS_W = 16;
  localparam int MS_W   = 15;
  localparam int CFG_DW = 16;
  localparam int CFG_IW = 3;
  localparam int MOVE_W = 16;

  localparam logic [CFG_IW-1:0] REG_ZERO_X      = 3'd0;
  localparam logic [CFG_IW-1:0] REG_ZERO_Y      = 3'd1;
  localparam logic [CFG_IW-1:0] REG_DEAD_BAND   = 3'd2;
  localparam logic [CFG_IW-1:0] REG_CURVE_THR   = 3'd3;
  localparam logic [CFG_IW-1:0] REG_SENSITIVITY = 3'd4;
  localparam logic [CFG_IW-1:0] REG_MAX_SPEED   = 3'd5;

  localparam logic [ZERO_W-1:0] RST_ZERO_X      = 12'd2048;
  localparam logic [ZERO_W-1:0] RST_ZERO_Y      = 12'd2048;
  localparam logic [DB_W-1:0]   RST_DEAD_BAND   = 13'd10;
  localparam logic [THR_W-1:0]  RST_CURVE_THR   = 13'd950;
  localparam logic [SENS_W-1:0] RST_SENSITIVITY = 16'd393;
  localparam logic [MS_W-1:0]   RST_MAX_SPEED   = 15'd2000;

  localparam logic [1:0] ACT_NONE    = 2'd0;
  localparam logic [1:0] ACT_PRESS   = 2'd1;
  localparam logic [1:0] ACT_RELEASE = 2'd2;

  typedef enum logic [1:0] {
    ALU_MUL  = 2'd0,
    ALU_DIV  = 2'd1,
    ALU_SQRT = 2'd2
  } alu_op_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic busy;
  } alu_rsp_t;

endpackage

`default_nettype wire

[hdl/jtm_alu.sv]
// Shared iterative arithmetic unit: shift-add multiply, restoring divide, digit square root.
// One bit (root: one digit) per cycle over a W-bit datapath; uses jtm_pkg.
`default_nettype none

module jtm_alu #(
  parameter int W = 54
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  jtm_pkg::alu_req_t     req_i,
  input  wire  [W-1:0]          a_i,
  input  wire  [W-1:0]          b_i,
  output jtm_pkg::alu_rsp_t     rsp_o,
  output logic [W-1:0]          res_o
);
  import jtm_pkg::*;

  localparam int H   = W / 2;
  localparam int RMW = H + 3;
  localparam int CW  = $clog2(W);

  logic          busy_q, done_q;
  alu_op_e       op_q;
  logic [CW-1:0] cnt_q;
  logic [W-1:0]  acc_q, sh_q, aux_q;
  logic [W-1:0]  acc_d, sh_d, aux_d;
  logic          bz_q;
  logic [CW-1:0] last;

  logic [W:0]     div_rem_n, div_diff;
  logic           div_ge;
  logic [RMW-1:0] sq_rem_n, sq_trial;
  logic           sq_ge;

  always_comb begin
    div_rem_n = {acc_q, sh_q[W-1]};
    div_diff  = div_rem_n - {1'b0, aux_q};
    div_ge    = (div_rem_n >= {1'b0, aux_q});
    sq_rem_n  = {acc_q[RMW-3:0], sh_q[W-1:W-2]};
    sq_trial  = RMW'({aux_q[H-1:0], 2'b01});
    sq_ge     = (sq_rem_n >= sq_trial);
    acc_d = acc_q;
    sh_d  = sh_q;
    aux_d = aux_q;
    case (op_q)
      ALU_MUL: begin
        acc_d = aux_q[0] ? acc_q + sh_q : acc_q;
        sh_d  = sh_q << 1;
        aux_d = aux_q >> 1;
      end
      ALU_DIV: begin
        acc_d = div_ge ? div_diff[W-1:0] : div_rem_n[W-1:0];
        sh_d  = {sh_q[W-2:0], div_ge};
      end
      ALU_SQRT: begin
        acc_d = W'(sq_ge ? sq_rem_n - sq_trial : sq_rem_n);
        sh_d  = sh_q << 2;
        aux_d = W'({aux_q[H-2:0], sq_ge});
      end
      default: begin
        acc_d = acc_q;
      end
    endcase
    last = (op_q == ALU_SQRT) ? CW'(H - 1) : CW'(W - 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= ALU_MUL;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        op_q   <= req_i.op;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      acc_q <= '0;
      sh_q  <= a_i;
      aux_q <= (req_i.op == ALU_SQRT) ? '0 : b_i;
      bz_q  <= (b_i == '0);
    end else if (busy_q) begin
      acc_q <= acc_d;
      sh_q  <= sh_d;
      aux_q <= aux_d;
    end
  end

  always_comb begin
    case (op_q)
      ALU_MUL:  res_o = acc_q;
      ALU_DIV:  res_o = bz_q ? '0 : sh_q;
      ALU_SQRT: res_o = W'(aux_q[H-1:0]);
      default:  res_o = '0;
    endcase
    rsp_o.done = done_q;
    rsp_o.busy = busy_q;
  end

endmodule

`default_nettype wire

[hdl/joystick_to_mouse_motion.sv]
// Top level of the joystick to mouse motion block: sequencer, registers and stream ports.
// Depends on jtm_pkg and jtm_alu.
`default_nettype none

// Turns one stick sample (two converter readings and an active-low button) into one
// mouse motion transfer with a radial dead band, a power 1.25 acceleration curve above
// the knee, Q0.16 gain and per-axis saturation, plus a press or release edge. A sample
// is taken only while the sequencer is idle and then runs through one shared shift-add
// multiply, restoring divide and square root unit of datapath width W (54 at default
// parameters). The result sits in an output register, so the next sample is taken
// while it waits; only the final load waits for that register to be free.
module joystick_to_mouse_motion #(
  parameter int ADC_BITS  = 12,
  parameter int FRAC_BITS = 8
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  // adc_x, adc_y, zero fill
  input  wire  [((2*ADC_BITS+7)/8)*8-1:0]  s_axis_tdata,
  // button_level
  input  wire                              s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  // move_x, move_y
  output logic [2*jtm_pkg::MOVE_W-1:0]     m_axis_tdata,
  // move_nonzero, button_action
  output logic [2:0]                       m_axis_tuser,
  input  wire                              cfg_we_i,
  input  wire  [jtm_pkg::CFG_IW-1:0]       cfg_idx_i,
  input  wire  [jtm_pkg::CFG_DW-1:0]       cfg_data_i
);
  import jtm_pkg::*;

  localparam int A    = ADC_BITS;
  localparam int F    = FRAC_BITS;
  localparam int SQW  = 2 * A + 1;
  localparam int LW   = A + 1 + F;
  localparam int R1W  = (LW + F + 1) / 2;
  localparam int RW   = (R1W + F + 1) / 2;
  localparam int RQW  = (R1W > RW) ? R1W : RW;
  localparam int TRW  = LW + RW;
  localparam int THW  = THR_W + F;
  localparam int BW   = (((TRW - F) > THW) ? (TRW - F) : THW) + 1;
  localparam int NW   = A + BW + SENS_W;
  localparam int SW   = 2 * A + 1 + 2 * F;
  localparam int W0   = (NW > SW) ? NW : SW;
  localparam int W    = W0 + (W0 % 2);
  localparam int EW   = ((LW > THW) ? LW : THW) + 1;
  localparam int CMW  = (SQW > 2 * THR_W) ? SQW : 2 * THR_W;

  typedef enum logic [21:0] {
    ST_IDLE = 22'h000001, ST_SQX  = 22'h000002, ST_SQY  = 22'h000004,
    ST_LEN1 = 22'h000008, ST_MX1  = 22'h000010, ST_DX1  = 22'h000020,
    ST_MY1  = 22'h000040, ST_DY1  = 22'h000080, ST_SQX2 = 22'h000100,
    ST_SQY2 = 22'h000200, ST_LOWX = 22'h000400, ST_LOWY = 22'h000800,
    ST_LEN2 = 22'h001000, ST_R1   = 22'h002000, ST_R2   = 22'h004000,
    ST_TR   = 22'h008000, ST_NS   = 22'h010000, ST_NX   = 22'h020000,
    ST_QX   = 22'h040000, ST_NY   = 22'h080000, ST_QY   = 22'h100000,
    ST_FIN  = 22'h200000
  } state_e;

  // configuration
  logic [ZERO_W-1:0]   zero_x_q, zero_y_q;
  logic [DB_W-1:0]     dead_band_q;
  logic [THR_W-1:0]    curve_thr_q;
  logic [SENS_W-1:0]   sensitivity_q;
  logic [MS_W-1:0]     max_speed_q;
  logic [2*DB_W-1:0]   db_sq_q;
  logic [2*THR_W-1:0]  thr_sq_q;

  // sequencer and datapath
  state_e              state_q, state_d;
  logic                issue_q, issue_d;
  logic                pressed_q;
  logic [1:0]          act_q;
  logic [A-1:0]        ax_q, ay_q, x1m_q, y1m_q;
  logic                sx_q, sy_q;
  logic [SQW-1:0]      sq_q, sq_sum;
  logic [LW-1:0]       len_q, len_less_db, t_w;
  logic [RQW-1:0]      r_q;
  logic [BW-1:0]       bent_q;
  logic [W-1:0]        prod_q, num_q;
  logic [MS_W-1:0]     qx_q, qy_q;
  logic [EW-1:0]       dbq, thq;

  logic                in_xfer;
  logic [15:0]         zx_full, zy_full;
  logic [A:0]          dx, dy;
  logic                pressed_now;

  alu_req_t            alu_req;
  alu_rsp_t            alu_rsp;
  logic [W-1:0]        alu_a, alu_b, alu_res;

  logic                out_valid_q;
  logic [2*MOVE_W-1:0] out_data_q;
  logic [2:0]          out_user_q;
  logic [MOVE_W-1:0]   mvx, mvy;

  function automatic logic [MS_W-1:0] clamp_f(input logic [W-1:0] v,
                                              input logic [MS_W-1:0] lim);
    logic [MS_W-1:0] r;
    r = (v > W'(lim)) ? lim : v[MS_W-1:0];
    return r;
  endfunction

  jtm_alu #(.W(W)) u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .a_i    (alu_a),
    .b_i    (alu_b),
    .rsp_o  (alu_rsp),
    .res_o  (alu_res)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  // inverted axes from the low ADC bits of the rest readings
  always_comb begin
    zx_full     = 16'(zero_x_q);
    zy_full     = 16'(zero_y_q);
    dx          = {1'b0, zx_full[A-1:0]} - {1'b0, s_axis_tdata[A-1:0]};
    dy          = {1'b0, zy_full[A-1:0]} - {1'b0, s_axis_tdata[2*A-1:A]};
    pressed_now = ~s_axis_tuser;
    dbq         = EW'(dead_band_q) << F;
    thq         = EW'(curve_thr_q) << F;
    len_less_db = LW'(EW'(len_q) - dbq);
    t_w         = LW'(EW'(len_q) - thq);
    sq_sum      = sq_q + SQW'(alu_res);
    mvx         = sx_q ? MOVE_W'(-MOVE_W'(qx_q)) : MOVE_W'(qx_q);
    mvy         = sy_q ? MOVE_W'(-MOVE_W'(qy_q)) : MOVE_W'(qy_q);
  end

  // operand selection for the shared unit
  always_comb begin
    alu_req.start = issue_q;
    alu_req.op    = ALU_MUL;
    alu_a         = '0;
    alu_b         = '0;
    case (state_q)
      ST_SQX:  begin alu_a = W'(ax_q);  alu_b = W'(ax_q); end
      ST_SQY:  begin alu_a = W'(ay_q);  alu_b = W'(ay_q); end
      ST_LEN1: begin alu_req.op = ALU_SQRT; alu_a = W'(sq_q) << (2 * F); end
      ST_MX1:  begin alu_a = W'(ax_q);  alu_b = W'(len_less_db); end
      ST_DX1:  begin alu_req.op = ALU_DIV; alu_a = prod_q; alu_b = W'(len_q); end
      ST_MY1:  begin alu_a = W'(ay_q);  alu_b = W'(len_less_db); end
      ST_DY1:  begin alu_req.op = ALU_DIV; alu_a = prod_q; alu_b = W'(len_q); end
      ST_SQX2: begin alu_a = W'(x1m_q); alu_b = W'(x1m_q); end
      ST_SQY2: begin alu_a = W'(y1m_q); alu_b = W'(y1m_q); end
      ST_LOWX: begin alu_a = W'(x1m_q); alu_b = W'(sensitivity_q); end
      ST_LOWY: begin alu_a = W'(y1m_q); alu_b = W'(sensitivity_q); end
      ST_LEN2: begin alu_req.op = ALU_SQRT; alu_a = W'(sq_q) << (2 * F); end
      ST_R1:   begin alu_req.op = ALU_SQRT; alu_a = W'(t_w) << F; end
      ST_R2:   begin alu_req.op = ALU_SQRT; alu_a = W'(r_q) << F; end
      ST_TR:   begin alu_a = W'(t_w);   alu_b = W'(r_q); end
      ST_NS:   begin alu_a = W'(bent_q); alu_b = W'(sensitivity_q); end
      ST_NX:   begin alu_a = W'(x1m_q); alu_b = num_q; end
      ST_QX:   begin
        alu_req.op = ALU_DIV; alu_a = prod_q; alu_b = W'(len_q) << SENS_W;
      end
      ST_NY:   begin alu_a = W'(y1m_q); alu_b = num_q; end
      ST_QY:   begin
        alu_req.op = ALU_DIV; alu_a = prod_q; alu_b = W'(len_q) << SENS_W;
      end
      default: begin alu_a = '0; end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_xfer) state_d = ST_SQX;
      ST_FIN:  if (!out_valid_q || m_axis_tready) state_d = ST_IDLE;
      default: begin
        if (alu_rsp.done) begin
          case (state_q)
            ST_SQX:  state_d = ST_SQY;
            ST_SQY:  state_d = (CMW'(sq_sum) < CMW'(db_sq_q)) ? ST_SQX2 : ST_LEN1;
            ST_LEN1: state_d = ST_MX1;
            ST_MX1:  state_d = ST_DX1;
            ST_DX1:  state_d = ST_MY1;
            ST_MY1:  state_d = ST_DY1;
            ST_DY1:  state_d = ST_SQX2;
            ST_SQX2: state_d = ST_SQY2;
            ST_SQY2: state_d = (CMW'(sq_sum) < CMW'(thr_sq_q)) ? ST_LOWX : ST_LEN2;
            ST_LOWX: state_d = ST_LOWY;
            ST_LOWY: state_d = ST_FIN;
            ST_LEN2: state_d = ST_R1;
            ST_R1:   state_d = ST_R2;
            ST_R2:   state_d = ST_TR;
            ST_TR:   state_d = ST_NS;
            ST_NS:   state_d = ST_NX;
            ST_NX:   state_d = ST_QX;
            ST_QX:   state_d = ST_NY;
            ST_NY:   state_d = ST_QY;
            ST_QY:   state_d = ST_FIN;
            default: state_d = ST_IDLE;
          endcase
        end
      end
    endcase
    issue_d = issue_q && !alu_req.start;
    if (state_d != state_q && state_d != ST_IDLE && state_d != ST_FIN) issue_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      issue_q       <= 1'b0;
      pressed_q     <= 1'b0;
      out_valid_q   <= 1'b0;
      zero_x_q      <= RST_ZERO_X;
      zero_y_q      <= RST_ZERO_Y;
      dead_band_q   <= RST_DEAD_BAND;
      curve_thr_q   <= RST_CURVE_THR;
      sensitivity_q <= RST_SENSITIVITY;
      max_speed_q   <= RST_MAX_SPEED;
    end else begin
      state_q <= state_d;
      issue_q <= issue_d;
      if (in_xfer) pressed_q <= pressed_now;
      if (state_q == ST_FIN && state_d == ST_IDLE) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_ZERO_X:      zero_x_q      <= cfg_data_i[ZERO_W-1:0];
          REG_ZERO_Y:      zero_y_q      <= cfg_data_i[ZERO_W-1:0];
          REG_DEAD_BAND:   dead_band_q   <= cfg_data_i[DB_W-1:0];
          REG_CURVE_THR:   curve_thr_q   <= cfg_data_i[THR_W-1:0];
          REG_SENSITIVITY: sensitivity_q <= cfg_data_i[SENS_W-1:0];
          REG_MAX_SPEED:   max_speed_q   <= cfg_data_i[MS_W-1:0];
          default:         max_speed_q   <= max_speed_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    db_sq_q  <= dead_band_q * dead_band_q;
    thr_sq_q <= curve_thr_q * curve_thr_q;
    if (in_xfer) begin
      ax_q  <= dx[A] ? A'(-dx) : dx[A-1:0];
      ay_q  <= dy[A] ? A'(-dy) : dy[A-1:0];
      sx_q  <= dx[A];
      sy_q  <= dy[A];
      x1m_q <= '0;
      y1m_q <= '0;
      if (pressed_now != pressed_q) begin
        act_q <= pressed_now ? ACT_PRESS : ACT_RELEASE;
      end else begin
        act_q <= ACT_NONE;
      end
    end
    if (alu_rsp.done) begin
      case (state_q)
        ST_SQX:  sq_q   <= SQW'(alu_res);
        ST_SQY:  sq_q   <= sq_sum;
        ST_LEN1: len_q  <= LW'(alu_res);
        ST_MX1:  prod_q <= alu_res;
        ST_DX1:  x1m_q  <= A'(alu_res);
        ST_MY1:  prod_q <= alu_res;
        ST_DY1:  y1m_q  <= A'(alu_res);
        ST_SQX2: sq_q   <= SQW'(alu_res);
        ST_SQY2: sq_q   <= sq_sum;
        ST_LOWX: qx_q   <= clamp_f(alu_res >> SENS_W, max_speed_q);
        ST_LOWY: qy_q   <= clamp_f(alu_res >> SENS_W, max_speed_q);
        ST_LEN2: len_q  <= LW'(alu_res);
        ST_R1:   r_q    <= RQW'(alu_res);
        ST_R2:   r_q    <= RQW'(alu_res);
        ST_TR:   bent_q <= BW'(alu_res >> F) + BW'(thq);
        ST_NS:   num_q  <= alu_res;
        ST_NX:   prod_q <= alu_res;
        ST_QX:   qx_q   <= clamp_f(alu_res, max_speed_q);
        ST_NY:   prod_q <= alu_res;
        ST_QY:   qy_q   <= clamp_f(alu_res, max_speed_q);
        default: prod_q <= prod_q;
      endcase
    end
    if (state_q == ST_FIN && state_d == ST_IDLE) begin
      out_data_q <= {mvy, mvx};
      out_user_q <= {act_q, (qx_q != '0) || (qy_q != '0)};
    end
  end

`ifndef SYNTHESIS
  a_ready_unit_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !alu_rsp.busy)
    else $error("sample taken while the arithmetic unit is busy");

  a_done_not_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_rsp.done |-> (state_q != ST_IDLE))
    else $error("arithmetic result with no step waiting for it");

  a_speed_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tdata[15] ? -m_axis_tdata[15:0] : m_axis_tdata[15:0])
                       <= 16'(max_speed_q)))
    else $error("horizontal motion beyond max speed");

  a_nonzero_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser[0] == (m_axis_tdata != '0)))
    else $error("motion flag disagrees with motion");
`endif

endmodule

`default_nettype wire
